// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/bbmd_pkg.sv -----
// Shared types and constants of the buck-boost mode and duty block.
// No dependencies; imported by every module of the block.
package bbmd_pkg;

    localparam int GAIN_WIDTH = 16;
    localparam int GAIN_IN_W  = 16;
    localparam int GAIN_USE_W = (GAIN_WIDTH < GAIN_IN_W) ? GAIN_WIDTH : GAIN_IN_W;
    localparam int GAIN_FRAC  = 12;
    localparam int DUTY_W     = 16;
    localparam int SAT_SHIFT  = DUTY_W - GAIN_FRAC;
    localparam int CNT_W      = $clog2(DUTY_W + 1);
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int MODE_W     = 2;

    localparam logic [DUTY_W-1:0] DUTY_ONE = DUTY_W'(1) << (DUTY_W - 1);
    localparam logic [31:0]       GAIN_ONE = 32'd1 << GAIN_FRAC;

    localparam logic [CFG_IDX_W-1:0] REG_BUCK_TO_MIXED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIXED_TO_BOOST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIXED_TO_BUCK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_TO_MIXED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIXED_FRACTION = 3'd4;

    localparam logic [CFG_W-1:0] RST_BUCK_TO_MIXED  = 16'd3482;
    localparam logic [CFG_W-1:0] RST_MIXED_TO_BOOST = 16'd4710;
    localparam logic [CFG_W-1:0] RST_MIXED_TO_BUCK  = 16'd3277;
    localparam logic [CFG_W-1:0] RST_BOOST_TO_MIXED = 16'd4301;
    localparam logic [CFG_W-1:0] RST_MIXED_FRACTION = 16'd26214;

    typedef enum logic [MODE_W-1:0] {
        MODE_STEP_DOWN = 2'd0,
        MODE_MIXED     = 2'd1,
        MODE_STEP_UP   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DUTY_W-1:0]     num;
        logic [GAIN_WIDTH-1:0] gain;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ----- hw/rtl/bbmd_div.sv -----
// Bit-serial restoring divider: saturated (num << GAIN_FRAC) / gain in Q1.15.
// Depends on bbmd_pkg.
module bbmd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bbmd_pkg::t_div_ctl            i_ctl,
    output bbmd_pkg::t_div_sts            o_sts,
    output logic [bbmd_pkg::DUTY_W-1:0]   o_quo
);
    import bbmd_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_sat, n_sat;
    logic [GAIN_WIDTH-1:0] r_rem, n_rem;
    logic [GAIN_WIDTH-1:0] r_gain, n_gain;
    logic [DUTY_W-1:0]     r_nlo, n_nlo;
    logic [DUTY_W-1:0]     r_quo, n_quo;

    logic [GAIN_WIDTH:0]   trial;
    logic [GAIN_WIDTH:0]   diff;
    logic                  fits;
    logic [31:0]           num_hi;
    logic                  sat_start;

    // One quotient bit per cycle: shift the next numerator bit into the
    // partial remainder and subtract the divisor where it fits.
    assign trial = {r_rem, r_nlo[DUTY_W-1]};
    assign diff  = trial - {1'b0, r_gain};
    assign fits  = (trial >= {1'b0, r_gain});

    // A quotient of 2^DUTY_W or more (a zero divisor too) saturates at once,
    // so the remaining quotient always fits in DUTY_W bits.
    assign num_hi    = 32'(i_ctl.num >> SAT_SHIFT);
    assign sat_start = (64'(i_ctl.num) >= (64'(i_ctl.gain) << SAT_SHIFT));

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sat  = r_sat;
        n_rem  = r_rem;
        n_gain = r_gain;
        n_nlo  = r_nlo;
        n_quo  = r_quo;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DUTY_W);
            n_sat  = sat_start;
            n_rem  = num_hi[GAIN_WIDTH-1:0];
            n_gain = i_ctl.gain;
            n_nlo  = {i_ctl.num[SAT_SHIFT-1:0], {GAIN_FRAC{1'b0}}};
            n_quo  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_rem = fits ? diff[GAIN_WIDTH-1:0] : trial[GAIN_WIDTH-1:0];
            n_nlo = {r_nlo[DUTY_W-2:0], 1'b0};
            n_quo = {r_quo[DUTY_W-2:0], fits};
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat  <= n_sat;
        r_rem  <= n_rem;
        r_gain <= n_gain;
        r_nlo  <= n_nlo;
        r_quo  <= n_quo;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo = (r_sat || (r_quo > DUTY_ONE)) ? DUTY_ONE : r_quo;

endmodule

// ----- hw/rtl/buck_boost_mode_duty.sv -----
// Top level: mode selection with hysteresis and leg duties of a
// four-switch buck-boost converter. Depends on bbmd_pkg and bbmd_div.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one gain word (Q4.12).
//   Output channel: o_out_valid / i_out_stall carry mode, buck leg duty and
//   boost leg duty (Q1.15, saturated at 1.0). Each gain word gives exactly
//   one result word.
//   Configuration: a write on i_cfg_we stores i_cfg_data into the register
//   at i_cfg_idx; indexes beyond the last register are ignored. Write only
//   while no word is in flight.
//   Flow: an accepted gain word loads the bit-serial divider, which works
//   out one quotient bit per cycle (16 bits); its registered done flag
//   moves the block to hand-over, which loads the output register. One word
//   is in work at a time, so no new gain word is taken before that load.
//   The result sits in an output register: a new gain word is taken while
//   the previous result still waits. A stalled receiver holds the finished
//   result in the divider until the output register frees up.
//   Reset: synchronous, active low; mode returns to buck, registers take
//   their default levels, and o_in_stall stays high while reset is held.
module buck_boost_mode_duty (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bbmd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bbmd_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bbmd_pkg::GAIN_IN_W-1:0]    i_gain,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bbmd_pkg::MODE_W-1:0]       o_mode,
    output logic [bbmd_pkg::DUTY_W-1:0]       o_buck_leg_duty,
    output logic [bbmd_pkg::DUTY_W-1:0]       o_boost_leg_duty
);
    import bbmd_pkg::*;

    t_state              r_state, n_state;
    t_mode               r_conv_mode, n_conv_mode;
    logic [CFG_W-1:0]    r_buck_to_mixed, r_mixed_to_boost;
    logic [CFG_W-1:0]    r_mixed_to_buck, r_boost_to_mixed;
    logic [CFG_W-1:0]    r_mixed_fraction;
    logic [DUTY_W-1:0]   r_buck, n_buck;
    logic                r_out_valid, n_out_valid;
    logic [MODE_W-1:0]   r_out_mode, n_out_mode;
    logic [DUTY_W-1:0]   r_out_buck, n_out_buck;
    logic [DUTY_W-1:0]   r_out_boost, n_out_boost;

    logic                stall;
    logic                accept;
    logic                load;
    logic                out_free;
    logic [GAIN_WIDTH-1:0] gain_u;
    logic [31:0]         gain32;
    t_div_ctl            div_ctl;
    t_div_sts            div_sts;
    logic [DUTY_W-1:0]   div_quo;

    assign gain_u   = GAIN_WIDTH'(i_gain[GAIN_USE_W-1:0]);
    assign gain32   = 32'(gain_u);
    assign out_free = !r_out_valid || !i_out_stall;

    // Mode transition: only neighbouring modes, strict compares.
    always_comb begin
        unique case (r_conv_mode)
            MODE_STEP_DOWN: begin
                n_conv_mode = (gain32 > 32'(r_buck_to_mixed)) ? MODE_MIXED : MODE_STEP_DOWN;
            end
            MODE_MIXED: begin
                if (gain32 > 32'(r_mixed_to_boost)) begin
                    n_conv_mode = MODE_STEP_UP;
                end else if (gain32 < 32'(r_mixed_to_buck)) begin
                    n_conv_mode = MODE_STEP_DOWN;
                end else begin
                    n_conv_mode = MODE_MIXED;
                end
            end
            MODE_STEP_UP: begin
                n_conv_mode = (gain32 < 32'(r_boost_to_mixed)) ? MODE_MIXED : MODE_STEP_UP;
            end
            default: begin
                n_conv_mode = MODE_STEP_DOWN;
            end
        endcase
    end

    // Buck duty of the new mode; the buck-mode case turns Q4.12 into Q1.15.
    always_comb begin
        unique case (n_conv_mode)
            MODE_MIXED:   n_buck = (r_mixed_fraction > DUTY_ONE) ? DUTY_ONE : r_mixed_fraction;
            MODE_STEP_UP: n_buck = DUTY_ONE;
            default:      n_buck = (gain32 > GAIN_ONE) ? DUTY_ONE
                                   : {gain32[GAIN_FRAC:0], {(DUTY_W - 1 - GAIN_FRAC){1'b0}}};
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_DIV;
            ST_DIV:  if (div_sts.done) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        stall = 1'b1;
        load  = 1'b0;
        unique case (r_state)
            ST_IDLE: stall = !i_rst_n;
            ST_DIV:  stall = 1'b1;
            ST_DONE: load  = out_free;
            default: stall = 1'b1;
        endcase
    end

    assign accept = i_in_valid && !stall;

    // The divider runs for every word; its quotient is ignored in buck mode.
    always_comb begin
        div_ctl.start = accept;
        div_ctl.num   = (n_conv_mode == MODE_MIXED) ? r_mixed_fraction : DUTY_ONE;
        div_ctl.gain  = gain_u;
    end

    bbmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_mode  = r_out_mode;
        n_out_buck  = r_out_buck;
        n_out_boost = r_out_boost;
        if (load) begin
            n_out_valid = 1'b1;
            n_out_mode  = r_conv_mode;
            n_out_buck  = r_buck;
            n_out_boost = (r_conv_mode == MODE_STEP_DOWN) ? DUTY_ONE : div_quo;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_conv_mode      <= MODE_STEP_DOWN;
            r_out_valid      <= 1'b0;
            r_buck_to_mixed  <= RST_BUCK_TO_MIXED;
            r_mixed_to_boost <= RST_MIXED_TO_BOOST;
            r_mixed_to_buck  <= RST_MIXED_TO_BUCK;
            r_boost_to_mixed <= RST_BOOST_TO_MIXED;
            r_mixed_fraction <= RST_MIXED_FRACTION;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_conv_mode <= n_conv_mode;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_BUCK_TO_MIXED:  r_buck_to_mixed  <= i_cfg_data;
                    REG_MIXED_TO_BOOST: r_mixed_to_boost <= i_cfg_data;
                    REG_MIXED_TO_BUCK:  r_mixed_to_buck  <= i_cfg_data;
                    REG_BOOST_TO_MIXED: r_boost_to_mixed <= i_cfg_data;
                    REG_MIXED_FRACTION: r_mixed_fraction <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buck <= n_buck;
        end
        r_out_mode  <= n_out_mode;
        r_out_buck  <= n_out_buck;
        r_out_boost <= n_out_boost;
    end

    assign o_in_stall       = stall;
    assign o_out_valid      = r_out_valid;
    assign o_mode           = r_out_mode;
    assign o_buck_leg_duty  = r_out_buck;
    assign o_boost_leg_duty = r_out_boost;

endmodule

// ----- hw/rtl/bbmd_checker.sv -----
// Port-level checks of the buck-boost mode and duty block, bound to its top.
// Depends on bbmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbmd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [bbmd_pkg::MODE_W-1:0]       o_mode,
    input  logic [bbmd_pkg::DUTY_W-1:0]       o_buck_leg_duty,
    input  logic [bbmd_pkg::DUTY_W-1:0]       o_boost_leg_duty
);
    import bbmd_pkg::*;

    // A stalled result word keeps its place and its contents.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mode) && $stable(o_buck_leg_duty) && $stable(o_boost_leg_duty), "stalled result word changed")

    // One word is in work at a time: after acceptance the input stalls.
    `ASSERT_CLK(a_one_in_work, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input taken while a word is in work")

    // Duties never exceed 1.0 and the mode code is never the unused one.
    `ASSERT_CLK(a_out_range, i_clk, i_rst_n, o_out_valid |-> (o_buck_leg_duty <= DUTY_ONE) && (o_boost_leg_duty <= DUTY_ONE) && (o_mode <= MODE_STEP_UP), "result word out of range")

    // Buck mode leaves the boost leg fully on; boost mode the buck leg.
    `ASSERT_CLK(a_leg_full, i_clk, i_rst_n, o_out_valid |-> ((o_mode != MODE_STEP_DOWN) || (o_boost_leg_duty == DUTY_ONE)) && ((o_mode != MODE_STEP_UP) || (o_buck_leg_duty == DUTY_ONE)), "idle leg not at full duty")

    // While reset is held, the input stalls, so no word is taken.
    `ASSERT_CLK_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |-> o_in_stall, "input open during reset")

endmodule

bind buck_boost_mode_duty bbmd_checker u_bbmd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_mode           (o_mode),
    .o_buck_leg_duty  (o_buck_leg_duty),
    .o_boost_leg_duty (o_boost_leg_duty)
);
